// ----- rtl/sct_pkg.sv -----
// Shared constants and helpers for the servo centering tracker.
// No dependencies.
`default_nettype none

package sct_pkg;

  localparam int COORD_W = 10;   // x, y, measure, centre, estimate
  localparam int ANGLE_W = 11;   // pan angle in tenths of a degree, up to 1800
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 16;
  localparam int CMP_W   = 7;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ESTIMATE = 2'd2;

  localparam logic [COORD_W-1:0] CENTRE_X_RST       = 10'd160;
  localparam logic [COORD_W-1:0] FIXED_ESTIMATE_RST = 10'd250;

  localparam logic                ACT_REPORT = 1'b0;
  localparam logic                ACT_ARM    = 1'b1;

  // floor(73*a/1000) == (a * 153093) >> 21 for every 11-bit a
  localparam logic [17:0] CMP_RECIP = 18'd153093;
  localparam int          CMP_SHIFT = 21;
  localparam logic [7:0]  CMP_BASE  = 8'd49;
  localparam logic [7:0]  CMP_SAT   = 8'd127;

  function automatic logic [CMP_W-1:0] servo_cmp(input logic [ANGLE_W-1:0] a);
    logic [28:0] prod;
    logic [7:0]  v;
    prod = 29'(a) * 29'(CMP_RECIP);
    v    = prod[28:CMP_SHIFT] + CMP_BASE;
    return (v > CMP_SAT) ? CMP_W'(CMP_SAT) : v[CMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/servo_centering_tracker.sv -----
// Servo centering tracker, top level: report handling, angle stepping, averaging.
// Depends on sct_pkg.
`default_nettype none

// Each accepted input word's result word is registered onto m_* in the next cycle.
// Throughput: one word per cycle; the result register frees itself in the
// cycle it is taken, so s_tready stays high while m_tready is high.
// Reset (rst, synchronous): tracker inactive, angle at ANGLE_MIN_TENTHS,
// lock/done/count/sum/estimate cleared, config registers at their defaults.
module servo_centering_tracker
  import sct_pkg::*;
#(
  parameter int SAMPLE_COUNT     = 20,
  parameter int ANGLE_MIN_TENTHS = 10,
  parameter int ANGLE_MAX_TENTHS = 900
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [31:0]          s_tdata,   // x_pos[9:0], y_pos[19:10], measure[29:20]
  input  wire logic                 s_tuser,   // action: 0 report, 1 arm
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [55:0]               m_tdata,   // servo_compare[6:0], locked[7], done_res[8],
                                               // estimate[18:9], echo_x[28:19],
                                               // echo_y[38:29], echo_measure[48:39]
  output logic                      m_tuser,   // echo_valid
  // config writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  // Constant-reciprocal divide of the sum by SAMPLE_COUNT: exact for any
  // 16-bit sum with shift SUM_W + ceil(log2(SAMPLE_COUNT)).
  localparam int          DIV_L = $clog2(SAMPLE_COUNT);
  localparam int          DIV_S = SUM_W + DIV_L;
  localparam longint      DIV_K = ((64'd1 << DIV_S) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam logic [16:0] DIV_K_V = 17'(DIV_K);

  localparam logic [ANGLE_W-1:0] ANG_MIN = ANGLE_W'(ANGLE_MIN_TENTHS);
  localparam logic [ANGLE_W-1:0] ANG_MAX = ANGLE_W'(ANGLE_MAX_TENTHS);
  localparam logic [CNT_W-1:0]   CNT_END = CNT_W'(SAMPLE_COUNT);

  // config registers
  logic [COORD_W-1:0] centre_x;
  logic               raw_mode;
  logic [COORD_W-1:0] fixed_estimate;

  // tracker state
  logic               active,       active_next;
  logic [ANGLE_W-1:0] angle,        angle_next;
  logic               lock_flag,    lock_flag_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [SUM_W-1:0]   measure_sum,  measure_sum_next;
  logic [COORD_W-1:0] estimate,     estimate_next;
  logic               done_flag,    done_flag_next;
  logic               echo;

  logic               accept;
  logic               in_action;
  logic [COORD_W-1:0] in_x, in_y, in_m;
  logic [ANGLE_W:0]   angle_inc;
  logic [ANGLE_W-1:0] angle_step;
  logic               lock_now;
  logic [SUM_W-1:0]   sum_add;
  logic [32:0]        div_prod;
  logic [32:0]        div_quot;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign in_action = s_tuser;
  assign in_x      = s_tdata[9:0];
  assign in_y      = s_tdata[19:10];
  assign in_m      = s_tdata[29:20];

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x       <= CENTRE_X_RST;
      raw_mode       <= 1'b0;
      fixed_estimate <= FIXED_ESTIMATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTRE_X:       centre_x       <= cfg_data;
        REG_RAW_MODE:       raw_mode       <= cfg_data[0];
        REG_FIXED_ESTIMATE: fixed_estimate <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // One tracking step: move toward centre with wrap, or lock on a match.
  always_comb begin
    angle_inc = {1'b0, angle} + 1'b1;
    if (in_x > centre_x) begin
      angle_step = (angle <= ANG_MIN) ? ANG_MAX : angle - 1'b1;
    end else begin
      angle_step = (angle_inc > {1'b0, ANG_MAX}) ? ANG_MIN : angle_inc[ANGLE_W-1:0];
    end
    lock_now = lock_flag || (in_x == centre_x);
  end

  assign sum_add  = measure_sum + SUM_W'(in_m);
  assign div_prod = 33'(sum_add) * 33'(DIV_K_V);
  assign div_quot = div_prod >> DIV_S;

  always_comb begin
    active_next       = active;
    angle_next        = angle;
    lock_flag_next    = lock_flag;
    sample_count_next = sample_count;
    measure_sum_next  = measure_sum;
    estimate_next     = estimate;
    done_flag_next    = done_flag;
    echo              = 1'b0;
    if (in_action == ACT_ARM) begin
      active_next       = 1'b1;
      lock_flag_next    = 1'b0;
      sample_count_next = '0;
      measure_sum_next  = '0;
      estimate_next     = '0;
      done_flag_next    = 1'b0;
    end else if (active) begin
      // angle only moves while unlocked and off centre
      if (!lock_now) begin
        angle_next = angle_step;
      end
      lock_flag_next = lock_now;
      if (raw_mode) begin
        echo = 1'b1;
        if (lock_now) begin
          estimate_next  = fixed_estimate;
          done_flag_next = 1'b1;
          active_next    = 1'b0;
        end
      end else if (lock_now) begin
        // done is never set while active, so every locked report counts
        sample_count_next = sample_count + 1'b1;
        measure_sum_next  = sum_add;
        if (sample_count + 1'b1 == CNT_END) begin
          done_flag_next = 1'b1;
          estimate_next  = div_quot[COORD_W-1:0];
          active_next    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      angle        <= ANG_MIN;
      lock_flag    <= 1'b0;
      sample_count <= '0;
      measure_sum  <= '0;
      estimate     <= '0;
      done_flag    <= 1'b0;
    end else if (accept) begin
      active       <= active_next;
      angle        <= angle_next;
      lock_flag    <= lock_flag_next;
      sample_count <= sample_count_next;
      measure_sum  <= measure_sum_next;
      estimate     <= estimate_next;
      done_flag    <= done_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0,
                  echo ? in_m : {COORD_W{1'b0}},
                  echo ? in_y : {COORD_W{1'b0}},
                  echo ? in_x : {COORD_W{1'b0}},
                  estimate_next,
                  done_flag_next,
                  lock_flag_next,
                  servo_cmp(angle_next)};
      m_tuser <= echo;
    end
  end

endmodule

`default_nettype wire
